// ===== rtl/mnrr_pkg.sv =====
// shared types and constants for the midi note round-robin router
// no dependencies
package mnrr_pkg;

	localparam int MAX_PORTS_DEF    = 16;
	localparam int NOTE_ENTRIES_DEF = 128;
	localparam int CFG_W            = 5;

	localparam logic [CFG_W-1:0] PORTS_RESET = 5'd1;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [1:0]  event_length;
		logic [12:0] frame_offset;
	} midi_evt_t;

	typedef struct packed {
		logic [3:0]  dest_port;
		logic        to_all;
		logic        dropped;
		logic [7:0]  status_out;
		logic [7:0]  first_out;
		logic [7:0]  second_out;
		logic [1:0]  length_out;
		logic [12:0] offset_out;
	} route_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

// ===== rtl/mnrr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module mnrr_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 128,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mnrr_mod_unit.sv =====
// restoring remainder unit, one dividend bit per cycle
// uses mnrr_pkg for the status struct
module mnrr_mod_unit #(
	parameter int  PW = 4,
	localparam int EW = PW + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PW-1:0]       dividend,
	input  logic [EW-1:0]       divisor,
	output mnrr_pkg::mod_stat_t stat,
	output logic [PW-1:0]       rem
);

	localparam int CNTW = $clog2(PW + 1);

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0]   r_q;
	logic [PW-1:0]   dvd_q;
	logic [EW-1:0]   dvs_q;
	logic [EW-1:0]   trial;
	logic [EW-1:0]   r_next;

	always_comb begin
		trial  = {r_q, dvd_q[PW-1]};
		r_next = (trial >= dvs_q) ? (trial - dvs_q) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(PW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			r_q   <= r_next[PW-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign stat.busy = run_q | done_q;
	assign stat.done = done_q;
	assign rem       = r_q;

endmodule

// ===== rtl/midi_note_round_robin_router.sv =====
// midi note round-robin router top level
// uses mnrr_pkg, mnrr_ram and mnrr_mod_unit
//
// usage:
//   an item (one midi event) is taken at a clock edge with start high and busy low.
//   one result per item comes out on result, marked by result_valid for one cycle,
//   after the item passes the stage and result registers. results cannot be held off by the receiver.
//   one item may be taken every cycle; the note owner table is a ram with a
//   registered read and a one-entry bypass for back-to-back notes on one slot.
//   note-on rotates over the ports in use, note-off goes to the recorded port
//   (or is flagged dropped when none is recorded), anything else goes to all.
//   ports_in_use is written through cfg_we / cfg_data. after a write, busy is high
//   while the rotation counter is reduced to the new port count by a bit-serial
//   remainder unit; no item is taken meanwhile.
//   reset: ports_in_use is 1, the counter is 0 and every note entry is empty.
//   valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module midi_note_round_robin_router #(
	parameter int MAX_PORTS    = mnrr_pkg::MAX_PORTS_DEF,
	parameter int NOTE_ENTRIES = mnrr_pkg::NOTE_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  mnrr_pkg::midi_evt_t     evt,
	output logic                    result_valid,
	output mnrr_pkg::route_t        result,
	input  logic                    cfg_we,
	input  logic [mnrr_pkg::CFG_W-1:0] cfg_data
);

	localparam int PW = $clog2(MAX_PORTS);
	localparam int EW = PW + 1;
	localparam int CW = (EW > mnrr_pkg::CFG_W) ? EW : mnrr_pkg::CFG_W;
	localparam int AW = $clog2(NOTE_ENTRIES);

	function automatic logic [EW-1:0] clamp_ports(input logic [mnrr_pkg::CFG_W-1:0] n);
		logic [CW-1:0] w;
		begin
			w = CW'(n);
			if (w == '0) begin
				w = CW'(1);
			end else if (w > CW'(MAX_PORTS)) begin
				w = CW'(MAX_PORTS);
			end
			return EW'(w);
		end
	endfunction

	logic [mnrr_pkg::CFG_W-1:0] ports_q;
	logic [PW-1:0]              last_q;
	logic [PW-1:0]              last_mod_q;
	logic [NOTE_ENTRIES-1:0]    note_vld_q;

	logic                       accept;
	logic [8:0]                 d1_ext;
	logic [AW-1:0]              slot_in;
	logic [EW-1:0]              eff_cur;
	logic [EW-1:0]              nxt_ext;
	logic [PW-1:0]              next_port;

	logic                       vld_s1;
	mnrr_pkg::midi_evt_t        evt_s1;
	logic [AW-1:0]              slot_s1;
	logic                       byp_hit_s1;
	logic [PW-1:0]              byp_port_s1;

	logic                       is_on;
	logic                       is_off;
	logic                       owned;
	logic [PW-1:0]              ram_rdata;
	logic [PW-1:0]              owner_port;
	mnrr_pkg::route_t           route_d;

	mnrr_pkg::mod_stat_t        mod_stat;
	logic [PW-1:0]              mod_rem;

	assign accept = start & ~busy;
	assign busy   = mod_stat.busy;

	// slot is note number modulo table size, note number < 2 * NOTE_ENTRIES
	always_comb begin
		d1_ext = {1'b0, evt.first_data};
		if (d1_ext >= 9'(NOTE_ENTRIES)) begin
			slot_in = AW'(d1_ext - 9'(NOTE_ENTRIES));
		end else begin
			slot_in = AW'(d1_ext);
		end
	end

	always_comb begin
		eff_cur   = clamp_ports(ports_q);
		nxt_ext   = {1'b0, last_mod_q} + EW'(1);
		next_port = (nxt_ext == eff_cur) ? '0 : nxt_ext[PW-1:0];
	end

	always_comb begin
		is_on      = vld_s1 && (evt_s1.event_length != 2'd0)
		             && (evt_s1.status_byte[7:4] == mnrr_pkg::KIND_NOTE_ON);
		is_off     = vld_s1 && (evt_s1.event_length != 2'd0)
		             && (evt_s1.status_byte[7:4] == mnrr_pkg::KIND_NOTE_OFF);
		owned      = note_vld_q[slot_s1];
		owner_port = byp_hit_s1 ? byp_port_s1 : ram_rdata;

		route_d.status_out = evt_s1.status_byte;
		route_d.first_out  = evt_s1.first_data;
		route_d.second_out = evt_s1.second_data;
		route_d.length_out = evt_s1.event_length;
		route_d.offset_out = evt_s1.frame_offset;
		route_d.dest_port  = '0;
		route_d.to_all     = 1'b0;
		route_d.dropped    = 1'b0;
		if (is_on) begin
			route_d.dest_port = 4'(next_port);
		end else if (is_off) begin
			if (owned) begin
				route_d.dest_port = 4'(owner_port);
			end else begin
				route_d.dropped = 1'b1;
			end
		end else begin
			route_d.to_all = 1'b1;
		end
	end

	mnrr_ram #(
		.WIDTH (PW),
		.DEPTH (NOTE_ENTRIES)
	) u_owner_ram (
		.clk   (clk),
		.we    (is_on),
		.waddr (slot_s1),
		.wdata (next_port),
		.raddr (slot_in),
		.rdata (ram_rdata)
	);

	mnrr_mod_unit #(
		.PW (PW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_we),
		.dividend (last_q),
		.divisor  (clamp_ports(cfg_data)),
		.stat     (mod_stat),
		.rem      (mod_rem)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_q      <= mnrr_pkg::PORTS_RESET;
			last_q       <= '0;
			last_mod_q   <= '0;
			note_vld_q   <= '0;
			vld_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			vld_s1       <= accept;
			result_valid <= vld_s1;
			if (cfg_we) begin
				ports_q <= cfg_data;
			end
			if (mod_stat.done) begin
				last_mod_q <= mod_rem;
			end else if (is_on) begin
				last_mod_q <= next_port;
			end
			if (is_on) begin
				last_q              <= next_port;
				note_vld_q[slot_s1] <= 1'b1;
			end else if (is_off) begin
				note_vld_q[slot_s1] <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1      <= evt;
			slot_s1     <= slot_in;
			byp_hit_s1  <= is_on && (slot_s1 == slot_in);
			byp_port_s1 <= next_port;
		end
		if (vld_s1) begin
			result <= route_d;
		end
	end

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 result_valid)
		else $error("taken item gave no result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.to_all && result.dropped))
		else $error("broadcast and dropped together");

	a_no_port_when_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.to_all || result.dropped)) |-> (result.dest_port == 4'd0))
		else $error("port set on broadcast or dropped item");

	a_counter_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ({1'b0, last_mod_q} < eff_cur))
		else $error("rotation counter not below port count");

	a_cfg_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("no busy after config write");

endmodule
